// File: rtl/core/shac_pkg.sv
// ----------------------------------------------------------------------------
// shac_pkg
// shared types, angle constants and helper functions of the hour angle core
// ----------------------------------------------------------------------------
package shac_pkg;

  // degrees with 16 fraction bits
  localparam logic signed [25:0] FULL_TURN    = 26'sd23592960;
  localparam logic signed [25:0] HALF_TURN    = 26'sd11796480;
  localparam logic signed [25:0] QUARTER_TURN = 26'sd5898240;
  localparam logic signed [25:0] NEG_HALF     = -26'sd11796480;
  localparam logic signed [25:0] NEG_QUARTER  = -26'sd5898240;
  localparam logic [24:0]        HALF_TURN_U  = 25'd11796480;
  localparam logic [29:0]        FULL_TURN_U  = 30'd23592960;

  // q30 start value of the rotation, pre-scaled by the gain
  localparam logic signed [31:0] CORDIC_GAIN  = 32'sd652032874;
  localparam int                 CORDIC_ITERS = 16;

  // width of a quotient of the argument division
  localparam int QUOT_BITS   = 31;
  // bits of the hour angle search
  localparam int SEARCH_BITS = 25;

  typedef struct packed {
    logic signed [25:0] z;
    logic               neg;
  } fold_t;

  // sideband carried alongside one search rotation
  typedef struct packed {
    logic [24:0]        h;
    logic [24:0]        t;
    logic               cand_ok;
    logic signed [31:0] carg;
    logic               nosol;
  } srch_sb_t;

  function automatic logic signed [25:0] atan_deg16(input int i);
    logic signed [25:0] r;
    case (i)
      0:       r = 26'sd2949120;
      1:       r = 26'sd1740967;
      2:       r = 26'sd919879;
      3:       r = 26'sd466945;
      4:       r = 26'sd234379;
      5:       r = 26'sd117304;
      6:       r = 26'sd58666;
      7:       r = 26'sd29335;
      8:       r = 26'sd14668;
      9:       r = 26'sd7334;
      10:      r = 26'sd3667;
      11:      r = 26'sd1833;
      12:      r = 26'sd917;
      13:      r = 26'sd458;
      14:      r = 26'sd229;
      15:      r = 26'sd115;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

  // fold an angle in [-180,180) into [-90,90], flag a negated cosine
  function automatic fold_t fold_angle(input logic signed [25:0] z);
    fold_t r;
    r.z   = z;
    r.neg = 1'b0;
    if (z > QUARTER_TURN) begin
      r.z   = HALF_TURN - z;
      r.neg = 1'b1;
    end else if (z < NEG_QUARTER) begin
      r.z   = NEG_HALF - z;
      r.neg = 1'b1;
    end
    return r;
  endfunction

  // reduce an angle of up to 2^27 magnitude modulo a full turn, then fold
  function automatic fold_t reduce_angle(input logic signed [29:0] v);
    logic [29:0]        u;
    logic signed [25:0] z;
    u = 30'(v) + (FULL_TURN_U << 3);
    for (int k = 3; k >= 0; k--) begin
      if (u >= (FULL_TURN_U << k)) begin
        u = u - (FULL_TURN_U << k);
      end
    end
    z = signed'(u[25:0]);
    if (z >= HALF_TURN) begin
      z = z - FULL_TURN;
    end
    return fold_angle(z);
  endfunction

endpackage

// File: rtl/core/shac_if.sv
// ----------------------------------------------------------------------------
// shac_if
// valid/ready channels of the hour angle core
// ----------------------------------------------------------------------------
interface shac_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] altitude_q8;
  logic signed [15:0] declination_q8;

  modport source (output valid, altitude_q8, declination_q8, input ready);
  modport sink   (input valid, altitude_q8, declination_q8, output ready);
endinterface

interface shac_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] hour_angle_q8;
  logic        no_solution;

  modport source (output valid, hour_angle_q8, no_solution, input ready);
  modport sink   (input valid, hour_angle_q8, no_solution, output ready);
endinterface

// File: rtl/core/shac_cordic.sv
// ----------------------------------------------------------------------------
// shac_cordic
// sixteen-stage rotation pipeline giving q30 sine and cosine of a folded angle
// ----------------------------------------------------------------------------
module shac_cordic #(
  parameter int SBW = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [25:0] in_z,
  input  logic               in_neg,
  input  logic [SBW-1:0]     in_sb,
  output logic               out_valid,
  output logic signed [31:0] out_sin,
  output logic signed [31:0] out_cos,
  output logic [SBW-1:0]     out_sb
);

  localparam int N = shac_pkg::CORDIC_ITERS;

  logic               vld [1:N];
  logic signed [31:0] cx  [1:N];
  logic signed [31:0] cy  [1:N];
  logic signed [25:0] cz  [1:N];
  logic               cn  [1:N];
  logic [SBW-1:0]     csb [1:N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic               v_in;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [25:0] z_in;
    logic               n_in;
    logic [SBW-1:0]     sb_in;

    if (i == 0) begin : g_first
      assign v_in  = in_valid;
      assign x_in  = shac_pkg::CORDIC_GAIN;
      assign y_in  = '0;
      assign z_in  = in_z;
      assign n_in  = in_neg;
      assign sb_in = in_sb;
    end else begin : g_next
      assign v_in  = vld[i];
      assign x_in  = cx[i];
      assign y_in  = cy[i];
      assign z_in  = cz[i];
      assign n_in  = cn[i];
      assign sb_in = csb[i];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (z_in >= 0) begin
          cx[i+1] <= x_in - (y_in >>> i);
          cy[i+1] <= y_in + (x_in >>> i);
          cz[i+1] <= z_in - shac_pkg::atan_deg16(i);
        end else begin
          cx[i+1] <= x_in + (y_in >>> i);
          cy[i+1] <= y_in - (x_in >>> i);
          cz[i+1] <= z_in + shac_pkg::atan_deg16(i);
        end
        cn[i+1]  <= n_in;
        csb[i+1] <= sb_in;
      end
    end
  end

  assign out_valid = vld[N];
  assign out_sin   = cy[N];
  assign out_cos   = cn[N] ? -cx[N] : cx[N];
  assign out_sb    = csb[N];

endmodule

// File: rtl/core/shac_divider.sv
// ----------------------------------------------------------------------------
// shac_divider
// pipelined restoring division, one quotient bit per stage, num <= den
// ----------------------------------------------------------------------------
module shac_divider #(
  parameter int SBW = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [32:0]                      in_num,
  input  logic [31:0]                      in_den,
  input  logic [SBW-1:0]                   in_sb,
  output logic                             out_valid,
  output logic [shac_pkg::QUOT_BITS-1:0]   out_quot,
  output logic [SBW-1:0]                   out_sb
);

  localparam int QB = shac_pkg::QUOT_BITS;

  logic           vld [1:QB];
  logic [32:0]    rem [1:QB];
  logic [31:0]    dvs [1:QB];
  logic [QB-1:0]  quo [1:QB];
  logic [SBW-1:0] dsb [1:QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic           v_in;
    logic [32:0]    r_in;
    logic [31:0]    d_in;
    logic [QB-1:0]  q_in;
    logic [SBW-1:0] sb_in;
    logic [32:0]    r_sh;

    if (j == 0) begin : g_first
      assign v_in  = in_valid;
      assign r_in  = in_num;
      assign d_in  = in_den;
      assign q_in  = '0;
      assign sb_in = in_sb;
      assign r_sh  = r_in;
    end else begin : g_next
      assign v_in  = vld[j];
      assign r_in  = rem[j];
      assign d_in  = dvs[j];
      assign q_in  = quo[j];
      assign sb_in = dsb[j];
      assign r_sh  = {r_in[31:0], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (r_sh >= {1'b0, d_in}) begin
          rem[j+1] <= r_sh - {1'b0, d_in};
          quo[j+1] <= q_in | (QB'(1) << (QB - 1 - j));
        end else begin
          rem[j+1] <= r_sh;
          quo[j+1] <= q_in;
        end
        dvs[j+1] <= d_in;
        dsb[j+1] <= sb_in;
      end
    end
  end

  assign out_valid = vld[QB];
  assign out_quot  = quo[QB];
  assign out_sb    = dsb[QB];

endmodule

// File: rtl/core/shac_search.sv
// ----------------------------------------------------------------------------
// shac_search
// bitwise arc cosine search, one rotation pipeline per hour angle bit
// ----------------------------------------------------------------------------
module shac_search (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [31:0]                  in_carg,
  input  logic                                in_nosol,
  output logic                                out_valid,
  output logic [shac_pkg::SEARCH_BITS-1:0]    out_h,
  output logic                                out_nosol
);

  localparam int NB  = shac_pkg::SEARCH_BITS;
  localparam int SBW = $bits(shac_pkg::srch_sb_t);

  logic               v_chain  [0:NB];
  logic [NB-1:0]      h_chain  [0:NB];
  logic signed [31:0] c_chain  [0:NB];
  logic               ns_chain [0:NB];

  assign v_chain[0]  = in_valid;
  assign h_chain[0]  = '0;
  assign c_chain[0]  = in_carg;
  assign ns_chain[0] = in_nosol;

  for (genvar k = 0; k < NB; k++) begin : g_bit
    logic [NB-1:0]          t;
    logic                   p_v;
    shac_pkg::fold_t        p_fold;
    shac_pkg::srch_sb_t     p_sb;
    logic                   o_v;
    logic signed [31:0]     o_sin;
    logic signed [31:0]     o_cos;
    shac_pkg::srch_sb_t     o_sb;

    // candidate: current angle with this bit set
    assign t = h_chain[k] | (NB'(1) << (NB - 1 - k));

    always_ff @(posedge clk) begin
      if (rst) begin
        p_v <= 1'b0;
      end else if (en) begin
        p_v <= v_chain[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_fold     <= shac_pkg::fold_angle(signed'({1'b0, t}));
        p_sb.h       <= h_chain[k];
        p_sb.t       <= t;
        p_sb.cand_ok <= (t <= shac_pkg::HALF_TURN_U);
        p_sb.carg    <= c_chain[k];
        p_sb.nosol   <= ns_chain[k];
      end
    end

    shac_cordic #(.SBW(SBW)) u_rot (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (p_v),
      .in_z      (p_fold.z),
      .in_neg    (p_fold.neg),
      .in_sb     (p_sb),
      .out_valid (o_v),
      .out_sin   (o_sin),
      .out_cos   (o_cos),
      .out_sb    (o_sb)
    );

    // keep the largest angle whose cosine still reaches the argument
    assign v_chain[k+1]  = o_v;
    assign h_chain[k+1]  = (o_sb.cand_ok && (o_cos >= o_sb.carg)) ? o_sb.t : o_sb.h;
    assign c_chain[k+1]  = o_sb.carg;
    assign ns_chain[k+1] = o_sb.nosol ^ (o_sin[0] & 1'b0);
  end

  assign out_valid = v_chain[NB];
  assign out_h     = h_chain[NB];
  assign out_nosol = ns_chain[NB];

endmodule

// File: rtl/core/solar_hour_angle_core.sv
// ----------------------------------------------------------------------------
// solar_hour_angle_core
// hour angle at which the sun reaches a target altitude for a set latitude
// ----------------------------------------------------------------------------
// req carries one item per handshake: target altitude and sun declination,
// signed degrees with ANGLE_FRAC_BITS fraction bits. rsp returns one item
// per request, in order: hour angle in [0,180] degrees (same format) and a
// no_solution flag, set with a zero angle when the cosine argument is out
// of range or the denominator is zero.
// cfg_we/cfg_wdata write the site latitude; change it only while idle.
// The pipeline takes one item per cycle unless rsp stalls. Its stages
// from accept to rsp.valid: 1 reduction, 16 rotation stages, 2
// product/check stages, 31 divider stages, 1 sign stage, 25 search bits
// of 17 stages each and the output register, most of them in the search.
// A stall on rsp freezes the whole pipeline; req.ready follows
// !rsp.valid || rsp.ready. Reset clears all valid bits and the latitude.
// ----------------------------------------------------------------------------
module solar_hour_angle_core #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  shac_in_if.sink           req,
  shac_out_if.source        rsp
);

  localparam int SH      = 16 - ANGLE_FRAC_BITS;
  localparam int HA_MAX  = ((180 << ANGLE_FRAC_BITS) > 65535) ? 65535
                                                             : (180 << ANGLE_FRAC_BITS);

  logic adv;
  logic signed [15:0] latitude;

  always_ff @(posedge clk) begin
    if (rst) begin
      latitude <= '0;
    end else if (cfg_we) begin
      latitude <= signed'(cfg_wdata);
    end
  end

  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // angle reduction
  logic            s0_v;
  shac_pkg::fold_t s0_a;
  shac_pkg::fold_t s0_l;
  shac_pkg::fold_t s0_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (adv) begin
      s0_v <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_a <= shac_pkg::reduce_angle(30'(req.altitude_q8) <<< SH);
      s0_l <= shac_pkg::reduce_angle(30'(latitude) <<< SH);
      s0_d <= shac_pkg::reduce_angle(30'(req.declination_q8) <<< SH);
    end
  end

  logic               r_v;
  logic signed [31:0] sa, ca, sl, cl, sd, cd;

  shac_cordic #(.SBW(1)) u_rot_alt (
    .clk (clk), .rst (rst), .en (adv),
    .in_valid (s0_v), .in_z (s0_a.z), .in_neg (s0_a.neg), .in_sb (1'b0),
    .out_valid (r_v), .out_sin (sa), .out_cos (ca), .out_sb ()
  );

  shac_cordic #(.SBW(1)) u_rot_lat (
    .clk (clk), .rst (rst), .en (adv),
    .in_valid (s0_v), .in_z (s0_l.z), .in_neg (s0_l.neg), .in_sb (1'b0),
    .out_valid (), .out_sin (sl), .out_cos (cl), .out_sb ()
  );

  shac_cordic #(.SBW(1)) u_rot_dec (
    .clk (clk), .rst (rst), .en (adv),
    .in_valid (s0_v), .in_z (s0_d.z), .in_neg (s0_d.neg), .in_sb (1'b0),
    .out_valid (), .out_sin (sd), .out_cos (cd), .out_sb ()
  );

  // products, floor shifted by 30
  logic               m_v;
  logic signed [31:0] m_sa;
  logic signed [31:0] m_p1;
  logic signed [31:0] m_p2;
  logic signed [63:0] prod1;
  logic signed [63:0] prod2;

  assign prod1 = 64'(sl) * 64'(sd);
  assign prod2 = 64'(cl) * 64'(cd);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (adv) begin
      m_v <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_sa <= sa;
      m_p1 <= prod1[61:30];
      m_p2 <= prod2[61:30];
    end
  end

  // numerator, magnitudes and range check
  logic signed [32:0] num;
  logic [32:0]        an;
  logic [31:0]        ad;
  logic               k_v;
  logic [32:0]        k_an;
  logic [31:0]        k_ad;
  logic               k_sign;
  logic               k_ns;

  assign num = 33'(m_sa) - 33'(m_p1);
  assign an  = num[32] ? 33'(-num) : 33'(num);
  assign ad  = m_p2[31] ? 32'(-m_p2) : 32'(m_p2);

  always_ff @(posedge clk) begin
    if (rst) begin
      k_v <= 1'b0;
    end else if (adv) begin
      k_v <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_an   <= an;
      k_ad   <= ad;
      k_sign <= num[32] ^ m_p2[31];
      k_ns   <= (m_p2 == 32'sd0) || (an > {1'b0, ad});
    end
  end

  logic                             q_v;
  logic [shac_pkg::QUOT_BITS-1:0]   q;
  logic [1:0]                       q_sb;

  shac_divider #(.SBW(2)) u_div (
    .clk (clk), .rst (rst), .en (adv),
    .in_valid (k_v), .in_num (k_an), .in_den (k_ad), .in_sb ({k_sign, k_ns}),
    .out_valid (q_v), .out_quot (q), .out_sb (q_sb)
  );

  // signed cosine argument
  logic               g_v;
  logic signed [31:0] g_carg;
  logic               g_ns;
  logic signed [31:0] qs;

  assign qs = signed'({1'b0, q});

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (adv) begin
      g_v <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_carg <= q_sb[1] ? -qs : qs;
      g_ns   <= q_sb[0];
    end
  end

  logic                               h_v;
  logic [shac_pkg::SEARCH_BITS-1:0]   h;
  logic                               h_ns;

  shac_search u_search (
    .clk (clk), .rst (rst), .en (adv),
    .in_valid (g_v), .in_carg (g_carg), .in_nosol (g_ns),
    .out_valid (h_v), .out_h (h), .out_nosol (h_ns)
  );

  // round half up to the output fraction, saturate
  logic [25:0] rnd;
  logic [25:0] res;

  if (SH > 0) begin : g_round
    assign rnd = {1'b0, h} + (26'(1) << (SH - 1));
  end else begin : g_exact
    assign rnd = {1'b0, h};
  end
  assign res = rnd >> SH;

  logic        o_v;
  logic [15:0] o_ha;
  logic        o_ns;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (adv) begin
      o_v <= h_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_ns <= h_ns;
      if (h_ns) begin
        o_ha <= '0;
      end else if (res > 26'hFFFF) begin
        o_ha <= 16'hFFFF;
      end else begin
        o_ha <= res[15:0];
      end
    end
  end

  assign rsp.valid         = o_v;
  assign rsp.hour_angle_q8 = o_ha;
  assign rsp.no_solution   = o_ns;

  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> s0_v)
    else $error("accepted item did not enter the pipeline");

  a_nosol_zero : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.no_solution) |-> (rsp.hour_angle_q8 == 16'd0))
    else $error("no_solution item carries a nonzero angle");

  a_angle_range : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.no_solution) |-> (rsp.hour_angle_q8 <= 16'(HA_MAX)))
    else $error("hour angle beyond half a turn");

  a_carg_range : assert property (@(posedge clk) disable iff (rst)
    (g_v && !g_ns) |-> ((g_carg <= 32'sd1073741824) && (g_carg >= -32'sd1073741824)))
    else $error("cosine argument beyond unit magnitude");

endmodule
